// File: hw/rtl/mpd_pkg.sv
// shared types and codes for the mqtt fixed-header deframer
// used by mpd_parse and mqtt_packet_deframer_top; no dependencies
package mpd_pkg;

   localparam int unsigned LEN_W = 28;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 28'd4094;

   // parser phases
   localparam logic [1:0] PH_CTRL = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_SKIP = 2'd3;

   // byte kinds
   localparam logic [2:0] KIND_CTRL      = 3'd0;
   localparam logic [2:0] KIND_LEN_DIGIT = 3'd1;
   localparam logic [2:0] KIND_TOPIC_LEN = 3'd2;
   localparam logic [2:0] KIND_TOPIC     = 3'd3;
   localparam logic [2:0] KIND_PKT_ID    = 3'd4;
   localparam logic [2:0] KIND_PAYLOAD   = 3'd5;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_LEN_LONG = 2'd1;
   localparam logic [1:0] ERR_OVERSIZE = 2'd2;

   // response kinds
   localparam logic [2:0] RESP_NONE     = 3'd0;
   localparam logic [2:0] RESP_CONNACK  = 3'd1;
   localparam logic [2:0] RESP_PINGRESP = 3'd2;
   localparam logic [2:0] RESP_SUBACK   = 3'd3;
   localparam logic [2:0] RESP_PUBACK   = 3'd4;
   localparam logic [2:0] RESP_CLOSE    = 3'd5;

   // packet types (upper nibble of control byte)
   localparam logic [3:0] PT_CONNECT    = 4'h1;
   localparam logic [3:0] PT_PUBLISH    = 4'h3;
   localparam logic [3:0] PT_SUBSCRIBE  = 4'h8;
   localparam logic [3:0] PT_PINGREQ    = 4'hC;
   localparam logic [3:0] PT_DISCONNECT = 4'hE;

   typedef struct packed {
      logic [1:0]       phase;
      logic [7:0]       ctrl;
      logic [LEN_W-1:0] len_acc;
      logic [1:0]       digit_cnt;
      logic [LEN_W-1:0] bytes_left;
      logic [LEN_W-1:0] body_pos;
      logic [15:0]      topic_size;
      logic [15:0]      pkt_id;
   } mpd_state_type;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic [2:0]       byte_kind;
      logic [3:0]       packet_type;
      logic [3:0]       packet_flags;
      logic [LEN_W-1:0] remaining_length;
      logic             end_of_packet;
      logic [1:0]       error_code;
      logic [2:0]       response_kind;
      logic [15:0]      ack_packet_id;
   } mpd_result_type;

endpackage

// File: hw/rtl/mpd_parse.sv
// next-state and result logic of the deframer for one received byte
// depends on mpd_pkg
module mpd_parse (
   input  mpd_pkg::mpd_state_type  cur,
   input  logic [7:0]              rx_byte,
   input  logic [mpd_pkg::LEN_W-1:0] max_len,
   output mpd_pkg::mpd_state_type  nxt,
   output mpd_pkg::mpd_result_type res
);
   import mpd_pkg::*;

   logic [LEN_W-1:0] digit_shifted;
   logic [LEN_W-1:0] acc_sum;
   logic [LEN_W-1:0] left_dec;
   logic [16:0]      topic_end;
   logic [17:0]      id_end;
   logic [3:0]       ptype;
   logic [1:0]       qos;
   logic [15:0]      topic_len_shift;
   logic [15:0]      pkt_id_shift;
   logic             pick;
   logic [LEN_W-1:0] pick_len;
   logic [15:0]      pick_id;

   assign ptype           = cur.ctrl[7:4];
   assign qos             = cur.ctrl[2:1];
   assign left_dec        = cur.bytes_left - LEN_W'(1);
   assign topic_end       = 17'd2 + {1'b0, cur.topic_size};
   assign id_end          = {1'b0, topic_end} + 18'd2;
   assign acc_sum         = cur.len_acc + digit_shifted;
   assign topic_len_shift = {cur.topic_size[7:0], rx_byte};
   assign pkt_id_shift    = {cur.pkt_id[7:0], rx_byte};

   always_comb begin
      case (cur.digit_cnt)
         2'd0: digit_shifted = LEN_W'({rx_byte[6:0]});
         2'd1: digit_shifted = LEN_W'({rx_byte[6:0], 7'd0});
         2'd2: digit_shifted = LEN_W'({rx_byte[6:0], 14'd0});
         default: digit_shifted = {rx_byte[6:0], 21'd0};
      endcase
   end

   always_comb begin
      nxt                  = cur;
      res.data_byte        = rx_byte;
      res.byte_kind        = KIND_CTRL;
      res.end_of_packet    = 1'b0;
      res.error_code       = ERR_NONE;
      res.response_kind    = RESP_NONE;
      res.ack_packet_id    = 16'd0;
      pick                 = 1'b0;

      case (cur.phase)
         PH_LEN: begin
            res.byte_kind = KIND_LEN_DIGIT;
            nxt.len_acc   = acc_sum;
            if (rx_byte[7]) begin
               if (cur.digit_cnt == 2'd3) begin
                  res.error_code = ERR_LEN_LONG;
                  nxt.phase      = PH_CTRL;
               end else begin
                  nxt.digit_cnt = cur.digit_cnt + 2'd1;
               end
            end else if (acc_sum > max_len) begin
               res.error_code = ERR_OVERSIZE;
               nxt.bytes_left = acc_sum;
               nxt.phase      = PH_SKIP;
            end else if (acc_sum == '0) begin
               res.end_of_packet = 1'b1;
               pick              = 1'b1;
               nxt.phase         = PH_CTRL;
            end else begin
               nxt.bytes_left = acc_sum;
               nxt.phase      = PH_BODY;
            end
         end
         PH_BODY: begin
            res.byte_kind = KIND_PAYLOAD;
            if (ptype == PT_PUBLISH) begin
               if (cur.body_pos < LEN_W'(2)) begin
                  res.byte_kind  = KIND_TOPIC_LEN;
                  nxt.topic_size = topic_len_shift;
               end else if (cur.body_pos < LEN_W'(topic_end)) begin
                  res.byte_kind = KIND_TOPIC;
               end else if (qos != 2'd0 && cur.body_pos < LEN_W'(id_end)) begin
                  res.byte_kind = KIND_PKT_ID;
                  nxt.pkt_id    = pkt_id_shift;
               end
            end else if (ptype == PT_SUBSCRIBE) begin
               if (cur.body_pos < LEN_W'(2)) begin
                  res.byte_kind = KIND_PKT_ID;
                  nxt.pkt_id    = pkt_id_shift;
               end
            end
            nxt.body_pos   = cur.body_pos + LEN_W'(1);
            nxt.bytes_left = left_dec;
            if (left_dec == '0) begin
               res.end_of_packet = 1'b1;
               pick              = 1'b1;
               nxt.phase         = PH_CTRL;
            end
         end
         PH_SKIP: begin
            res.byte_kind  = KIND_PAYLOAD;
            nxt.bytes_left = left_dec;
            if (left_dec == '0) begin
               res.end_of_packet = 1'b1;
               nxt.phase         = PH_CTRL;
            end
         end
         default: begin
            nxt.ctrl       = rx_byte;
            nxt.len_acc    = '0;
            nxt.digit_cnt  = 2'd0;
            nxt.bytes_left = '0;
            nxt.body_pos   = '0;
            nxt.topic_size = 16'd0;
            nxt.pkt_id     = 16'd0;
            nxt.phase      = PH_LEN;
         end
      endcase

      // response choice sees the state as updated by this byte
      pick_len = nxt.len_acc;
      pick_id  = nxt.pkt_id;
      if (pick) begin
         case (ptype)
            PT_CONNECT:    res.response_kind = RESP_CONNACK;
            PT_PINGREQ:    res.response_kind = RESP_PINGRESP;
            PT_DISCONNECT: res.response_kind = RESP_CLOSE;
            PT_SUBSCRIBE: begin
               if (pick_len >= LEN_W'(2)) begin
                  res.response_kind = RESP_SUBACK;
                  res.ack_packet_id = pick_id;
               end
            end
            PT_PUBLISH: begin
               if (qos == 2'd1) begin
                  res.response_kind = RESP_PUBACK;
                  res.ack_packet_id = pick_id;
               end
            end
            default: res.response_kind = RESP_NONE;
         endcase
      end

      res.packet_type      = nxt.ctrl[7:4];
      res.packet_flags     = nxt.ctrl[3:0];
      res.remaining_length = nxt.len_acc;
   end

endmodule

// File: hw/rtl/mqtt_packet_deframer_top.sv
// top level of the mqtt 3.1.1 fixed-header deframer: request register,
// parser state, result register; depends on mpd_pkg and mpd_parse
//
// Takes one received stream byte per request and returns one tagged result per
// byte, one byte per clock while no result waits under rsp_stall. A byte is
// captured in the request register, then parsed against the packet state into
// the result register. Both stages advance together whenever the result
// register is empty or being taken; req_stall is high only while a result waits
// under rsp_stall. csr_wr_data sets the longest accepted remaining length
// (reset 4094); write it only while idle.
module mqtt_packet_deframer_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_data_byte,
   output logic [2:0]                  rsp_byte_kind,
   output logic [3:0]                  rsp_packet_type,
   output logic [3:0]                  rsp_packet_flags,
   output logic [mpd_pkg::LEN_W-1:0]   rsp_remaining_length,
   output logic                        rsp_end_of_packet,
   output logic [1:0]                  rsp_error_code,
   output logic [2:0]                  rsp_response_kind,
   output logic [15:0]                 rsp_ack_packet_id,
   input  logic                        csr_wr_en,
   input  logic [mpd_pkg::LEN_W-1:0]   csr_wr_data
);
   import mpd_pkg::*;

   logic             advance;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic [LEN_W-1:0] max_len_ff;
   mpd_state_type    state_ff;
   mpd_state_type    state_in;
   mpd_result_type   res_in;
   mpd_result_type   res_ff;
   logic             rsp_valid_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   mpd_parse u_parse (
      .cur     (state_ff),
      .rx_byte (in_byte_ff),
      .max_len (max_len_ff),
      .nxt     (state_in),
      .res     (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else if (advance) begin
         in_valid_ff  <= req_valid;
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff <= req_rx_byte;
         if (in_valid_ff) begin
            res_ff <= res_in;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data_byte        = res_ff.data_byte;
   assign rsp_byte_kind        = res_ff.byte_kind;
   assign rsp_packet_type      = res_ff.packet_type;
   assign rsp_packet_flags     = res_ff.packet_flags;
   assign rsp_remaining_length = res_ff.remaining_length;
   assign rsp_end_of_packet    = res_ff.end_of_packet;
   assign rsp_error_code       = res_ff.error_code;
   assign rsp_response_kind    = res_ff.response_kind;
   assign rsp_ack_packet_id    = res_ff.ack_packet_id;

endmodule
